// ===== rtl/bcc_pkg.sv =====
// bcc_pkg: shared types and constants of the barometer compensation core
// calibration record, register indexes, sideband records between stages
// no dependencies
`default_nettype none

package bcc_pkg;

   // decoded calibration coefficients
   typedef struct packed {
      logic signed [15:0] ac1;
      logic signed [15:0] ac2;
      logic signed [15:0] ac3;
      logic        [15:0] ac4;
      logic        [15:0] ac5;
      logic        [15:0] ac6;
      logic signed [15:0] b1;
      logic signed [15:0] b2;
      logic signed [15:0] mc;
      logic signed [15:0] md;
      logic        [1:0]  oss;
   } cal_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_CAL_A = 2'd0,
      CSR_CAL_B = 2'd1,
      CSR_CAL_C = 2'd2,
      CSR_OSS   = 2'd3
   } csr_index_type;

   // words carried alongside the temperature divider
   typedef struct packed {
      logic signed [17:0] x1;
      logic        [18:0] up;
      logic               neg;
      logic               fault;
   } front_side_type;

   // words carried alongside the pressure divider
   typedef struct packed {
      logic               big;
      logic signed [15:0] temp;
      logic               fault;
   } mid_side_type;

   localparam int TEMP_NUM_W = 27;
   localparam int TEMP_DEN_W = 18;
   localparam int PRES_NUM_W = 32;
   localparam int PRES_DEN_W = 17;

   localparam logic signed [28:0] B6_OFFSET  = 29'sd4000;
   localparam logic        [15:0] PRES_SCALE = 16'd50000;
   localparam logic        [31:0] X3_OFFSET  = 32'd32768;
   localparam logic        [11:0] PC_X1      = 12'd3038;
   localparam logic signed [15:0] PC_X2      = -16'sd7357;
   localparam logic signed [45:0] PC_OFFSET  = 46'sd3791;
   localparam logic        [31:0] BIG_LIMIT  = 32'h8000_0000;

   localparam logic signed [15:0] TEMP_MAX = 16'sh7fff;
   localparam logic signed [15:0] TEMP_MIN = -16'sh8000;
   localparam logic        [17:0] PRES_MAX = 18'h3ffff;

endpackage

`default_nettype wire

// ===== rtl/barometer_compensation_core.sv =====
// barometer_compensation_core: top level of the barometer compensation core
// instantiates bcc_front, bcc_div (twice), bcc_mid and bcc_tail; uses bcc_pkg
//
// Takes one raw temperature / raw pressure pair per word and returns the
// compensated temperature (0.1 degree, saturated) and pressure (Pa,
// saturated), with a fault flag and zero results when a divisor is zero.
// The core accepts one word every cycle while the output is not held, and has
// 4 front stages, 27 stages of the temperature divider, 11 middle
// stages, 32 stages of the pressure divider and 5 correction stages, one
// quotient bit per divider stage. The whole pipeline moves together and
// holds while a finished result waits on rsp_tready. Calibration writes
// take effect at once and are meant for an empty pipeline.
`default_nettype none

module barometer_compensation_core
   import bcc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request words
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // raw_temperature [15:0], raw_pressure [39:16]
   // result words
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // temperature [15:0], pressure [33:16], zero fill
   output logic [0:0]       rsp_tuser,   // div_fault [0]
   // calibration writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   cal_type               cal_ff;
   logic                  adv;
   logic                  f_valid;
   logic [TEMP_NUM_W-1:0] f_num;
   logic [TEMP_DEN_W-1:0] f_den;
   front_side_type        f_side;
   logic                  d1_valid;
   logic [TEMP_NUM_W-1:0] d1_quo;
   logic [$bits(front_side_type)-1:0] d1_side;
   logic                  m_valid;
   logic [PRES_NUM_W-1:0] m_num;
   logic [PRES_DEN_W-1:0] m_den;
   mid_side_type          m_side;
   logic                  d2_valid;
   logic [PRES_NUM_W-1:0] d2_quo;
   logic [$bits(mid_side_type)-1:0] d2_side;
   logic signed [15:0]    temperature;
   logic        [17:0]    pressure;
   logic                  div_fault;

   // calibration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_CAL_A: begin
               cal_ff.ac1 <= csr_data[63:48];
               cal_ff.ac2 <= csr_data[47:32];
               cal_ff.ac3 <= csr_data[31:16];
               cal_ff.ac4 <= csr_data[15:0];
            end
            CSR_CAL_B: begin
               cal_ff.ac5 <= csr_data[63:48];
               cal_ff.ac6 <= csr_data[47:32];
               cal_ff.b1  <= csr_data[31:16];
               cal_ff.b2  <= csr_data[15:0];
            end
            CSR_CAL_C: begin
               cal_ff.mc <= csr_data[31:16];
               cal_ff.md <= csr_data[15:0];
            end
            CSR_OSS: begin
               cal_ff.oss <= csr_data[1:0];
            end
            default: begin
               cal_ff <= cal_ff;
            end
         endcase
      end
   end

   // whole pipeline advances unless the output word is held
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   bcc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .cal             (cal_ff),
      .in_valid        (req_tvalid),
      .raw_temperature (req_tdata[15:0]),
      .raw_pressure    (req_tdata[39:16]),
      .out_valid       (f_valid),
      .out_num         (f_num),
      .out_den         (f_den),
      .out_side        (f_side)
   );

   bcc_div #(
      .NW (TEMP_NUM_W),
      .DW (TEMP_DEN_W),
      .SW ($bits(front_side_type))
   ) u_div_temp (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_num    (f_num),
      .in_den    (f_den),
      .in_side   (f_side),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_side  (d1_side)
   );

   bcc_mid u_mid (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cal       (cal_ff),
      .in_valid  (d1_valid),
      .in_quo    (d1_quo),
      .in_side   (front_side_type'(d1_side)),
      .out_valid (m_valid),
      .out_num   (m_num),
      .out_den   (m_den),
      .out_side  (m_side)
   );

   bcc_div #(
      .NW (PRES_NUM_W),
      .DW (PRES_DEN_W),
      .SW ($bits(mid_side_type))
   ) u_div_pres (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (m_valid),
      .in_num    (m_num),
      .in_den    (m_den),
      .in_side   (m_side),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_side  (d2_side)
   );

   bcc_tail u_tail (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d2_valid),
      .in_quo    (d2_quo),
      .in_side   (mid_side_type'(d2_side)),
      .out_valid (rsp_tvalid),
      .out_temp  (temperature),
      .out_pres  (pressure),
      .out_fault (div_fault)
   );

   // result word packing
   assign rsp_tdata = {6'b0, pressure, temperature};
   assign rsp_tuser = div_fault;

endmodule

`default_nettype wire

// ===== rtl/bcc_div.sv =====
// bcc_div: pipelined restoring divider, one quotient bit per stage
// unsigned numerator and divisor, sideband word travels with each item
// uses nothing outside this file
`default_nettype none

module bcc_div #(
   parameter int NW = 27,
   parameter int DW = 18,
   parameter int SW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   input  wire logic          in_valid,
   input  wire logic [NW-1:0] in_num,
   input  wire logic [DW-1:0] in_den,
   input  wire logic [SW-1:0] in_side,
   output logic               out_valid,
   output logic      [NW-1:0] out_quo,
   output logic      [SW-1:0] out_side
);

   logic          valid_ff [NW];
   logic [NW-1:0] num_ff   [NW];
   logic [DW-1:0] rem_ff   [NW];
   logic [DW-1:0] den_ff   [NW];
   logic [SW-1:0] side_ff  [NW];

   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic          valid_s;
      logic [NW-1:0] num_s;
      logic [DW-1:0] rem_s;
      logic [DW-1:0] den_s;
      logic [SW-1:0] side_s;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_in;

      if (i == 0) begin : g_first
         assign valid_s = in_valid;
         assign num_s   = in_num;
         assign rem_s   = '0;
         assign den_s   = in_den;
         assign side_s  = in_side;
      end else begin : g_next
         assign valid_s = valid_ff[i-1];
         assign num_s   = num_ff[i-1];
         assign rem_s   = rem_ff[i-1];
         assign den_s   = den_ff[i-1];
         assign side_s  = side_ff[i-1];
      end

      // shift in next numerator bit, subtract when it fits
      assign trial  = {rem_s, num_s[NW-1]};
      assign diff   = trial - {1'b0, den_s};
      assign ge     = (trial >= {1'b0, den_s});
      assign rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (adv) begin
            valid_ff[i] <= valid_s;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            num_ff[i]  <= {num_s[NW-2:0], ge};
            rem_ff[i]  <= rem_in;
            den_ff[i]  <= den_s;
            side_ff[i] <= side_s;
         end
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign out_quo   = num_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule

`default_nettype wire

// ===== rtl/bcc_front.sv =====
// bcc_front: raw temperature to divider operands, four stages
// depends on bcc_pkg for the calibration record and sideband type
`default_nettype none

module bcc_front
   import bcc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           adv,
   input  wire cal_type        cal,
   input  wire logic           in_valid,
   input  wire logic [15:0]    raw_temperature,
   input  wire logic [23:0]    raw_pressure,
   output logic                out_valid,
   output logic [TEMP_NUM_W-1:0] out_num,
   output logic [TEMP_DEN_W-1:0] out_den,
   output front_side_type      out_side
);

   logic                      v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [16:0]        d_ff, d_in;
   logic        [18:0]        up1_ff, up2_ff, up3_ff, up4_ff, up_in;
   logic        [23:0]        up_full;
   logic signed [33:0]        prod_x1;
   logic signed [17:0]        x1_2_ff, x1_3_ff, x1_4_ff;
   logic signed [18:0]        den_ff, den_in;
   logic signed [26:0]        num_s;
   logic [TEMP_NUM_W-1:0]     nmag_ff, nmag_in;
   logic signed [18:0]        dneg;
   logic [TEMP_DEN_W-1:0]     dmag_ff, dmag_in;
   logic                      neg_ff, fault_ff;

   // stage 1: offset the temperature word, align pressure by oversampling
   always_comb begin
      d_in    = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.ac6});
      up_full = raw_pressure >> (4'd8 - {2'b00, cal.oss});
      up_in   = up_full[18:0];
   end

   // stage 2: scale by ac5
   assign prod_x1 = d_ff * $signed({1'b0, cal.ac5});

   // stage 3: divisor x1 + md
   assign den_in = x1_2_ff + cal.md;

   // stage 4: magnitudes and quotient sign
   always_comb begin
      num_s   = {cal.mc, 11'b0};
      nmag_in = num_s[26] ? TEMP_NUM_W'(-num_s) : TEMP_NUM_W'(num_s);
      dneg    = -den_ff;
      dmag_in = den_ff[18] ? dneg[TEMP_DEN_W-1:0] : den_ff[TEMP_DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff     <= d_in;
         up1_ff   <= up_in;
         x1_2_ff  <= prod_x1[32:15];
         up2_ff   <= up1_ff;
         den_ff   <= den_in;
         x1_3_ff  <= x1_2_ff;
         up3_ff   <= up2_ff;
         nmag_ff  <= nmag_in;
         dmag_ff  <= dmag_in;
         neg_ff   <= cal.mc[15] ^ den_ff[18];
         fault_ff <= (den_ff == '0);
         x1_4_ff  <= x1_3_ff;
         up4_ff   <= up3_ff;
      end
   end

   assign out_valid      = v4_ff;
   assign out_num        = nmag_ff;
   assign out_den        = dmag_ff;
   assign out_side.x1    = x1_4_ff;
   assign out_side.up    = up4_ff;
   assign out_side.neg   = neg_ff;
   assign out_side.fault = fault_ff;

endmodule

`default_nettype wire

// ===== rtl/bcc_mid.sv =====
// bcc_mid: temperature result and pressure divider operands, eleven stages
// depends on bcc_pkg for the calibration record and sideband types
`default_nettype none

module bcc_mid
   import bcc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire cal_type               cal,
   input  wire logic                  in_valid,
   input  wire logic [TEMP_NUM_W-1:0] in_quo,
   input  wire front_side_type        in_side,
   output logic                       out_valid,
   output logic [PRES_NUM_W-1:0]      out_num,
   output logic [PRES_DEN_W-1:0]      out_den,
   output mid_side_type               out_side
);

   localparam int NS = 11;

   logic               v_ff [NS];
   logic               f_ff [NS];
   logic        [18:0] up_ff [9];
   logic signed [15:0] t_ff [NS];

   logic signed [27:0] x2_1_ff, x2_in;
   logic signed [17:0] x1_1_ff;
   logic signed [28:0] b5_2_ff;
   logic signed [29:0] t_sum;
   logic signed [25:0] t_shift;
   logic signed [15:0] t_in;
   logic signed [27:0] b6_3_ff;
   logic signed [28:0] b6_full;
   logic signed [55:0] sq_prod;
   logic signed [43:0] a2_prod;
   logic signed [43:0] a3_prod;
   logic        [41:0] sq_4_ff;
   logic signed [32:0] a2_4_ff, a2_5_ff;
   logic signed [30:0] a3_4_ff, a3_5_ff;
   logic signed [59:0] x1a_prod, x2b_prod;
   logic signed [48:0] x1a_5_ff;
   logic signed [43:0] x2b_5_ff;
   logic signed [49:0] x3a_6_ff;
   logic signed [44:0] sb_6_ff;
   logic signed [44:0] sb_shift;
   logic signed [50:0] v_7_ff;
   logic        [31:0] m32_7_ff;
   logic signed [52:0] v_ext, w_8_ff;
   logic        [47:0] b4_prod;
   logic [PRES_DEN_W-1:0] b4_8_ff, b4_9_ff, b4_10_ff, b4_11_ff;
   logic signed [52:0] w_round;
   logic        [31:0] b3l_9_ff;
   logic        [31:0] dd_10_ff;
   logic        [15:0] scale;
   logic        [47:0] b7_prod;
   logic        [31:0] b7_11_ff;
   logic               big;

   // stage 1: apply the quotient sign
   assign x2_in = in_side.neg ? -$signed({1'b0, in_quo}) : $signed({1'b0, in_quo});

   // stage 3: temperature rounding and saturation, b6
   always_comb begin
      t_sum   = b5_2_ff + 30'sd8;
      t_shift = t_sum[29:4];
      if (t_shift > TEMP_MAX) begin
         t_in = TEMP_MAX;
      end else if (t_shift < TEMP_MIN) begin
         t_in = TEMP_MIN;
      end else begin
         t_in = t_shift[15:0];
      end
      b6_full = b5_2_ff - B6_OFFSET;
   end

   // stage 4: square of b6 and the two linear terms
   assign sq_prod = b6_3_ff * b6_3_ff;
   assign a2_prod = b6_3_ff * cal.ac2;
   assign a3_prod = b6_3_ff * cal.ac3;

   // stage 5: quadratic terms
   assign x1a_prod = $signed({1'b0, sq_4_ff}) * cal.b2;
   assign x2b_prod = $signed({1'b0, sq_4_ff}) * cal.b1;

   // stage 7: low word of x3 + 32768
   assign sb_shift = sb_6_ff >>> 2;

   // stage 8: oversampling scale of b3, b4 product
   assign v_ext   = v_7_ff;
   assign b4_prod = {16'b0, m32_7_ff} * {32'b0, cal.ac4};

   // stage 9: b3 as truncating quotient by four
   assign w_round = w_8_ff + (w_8_ff[52] ? 53'sd3 : 53'sd0);

   // stage 11: b7, low 32 bits
   assign scale   = PRES_SCALE >> cal.oss;
   assign b7_prod = {16'b0, dd_10_ff} * {32'b0, scale};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // carried words
         f_ff[0]  <= in_side.fault;
         up_ff[0] <= in_side.up;
         for (int i = 1; i < NS; i++) begin
            if (i == 8) begin
               f_ff[i] <= f_ff[i-1] | (b4_8_ff == '0);
            end else begin
               f_ff[i] <= f_ff[i-1];
            end
         end
         for (int i = 1; i < 9; i++) begin
            up_ff[i] <= up_ff[i-1];
         end
         t_ff[0] <= '0;
         t_ff[1] <= '0;
         t_ff[2] <= t_in;
         for (int i = 3; i < NS; i++) begin
            t_ff[i] <= t_ff[i-1];
         end

         x2_1_ff  <= x2_in;
         x1_1_ff  <= in_side.x1;
         b5_2_ff  <= x1_1_ff + x2_1_ff;
         b6_3_ff  <= b6_full[27:0];
         sq_4_ff  <= sq_prod[53:12];
         a2_4_ff  <= a2_prod[43:11];
         a3_4_ff  <= a3_prod[43:13];
         x1a_5_ff <= x1a_prod[59:11];
         x2b_5_ff <= x2b_prod[59:16];
         a2_5_ff  <= a2_4_ff;
         a3_5_ff  <= a3_4_ff;
         x3a_6_ff <= x1a_5_ff + a2_5_ff;
         sb_6_ff  <= x2b_5_ff + a3_5_ff + 45'sd2;
         v_7_ff   <= x3a_6_ff + $signed({cal.ac1, 2'b00});
         m32_7_ff <= sb_shift[31:0] + X3_OFFSET;
         w_8_ff   <= (v_ext <<< cal.oss) + 53'sd2;
         b4_8_ff  <= b4_prod[31:15];
         b3l_9_ff <= w_round[33:2];
         b4_9_ff  <= b4_8_ff;
         dd_10_ff <= {13'b0, up_ff[8]} - b3l_9_ff;
         b4_10_ff <= b4_9_ff;
         b7_11_ff <= b7_prod[31:0];
         b4_11_ff <= b4_10_ff;
      end
   end

   // numerator chosen so the quotient fits 32 bits in both branches
   assign big            = (b7_11_ff >= BIG_LIMIT);
   assign out_valid      = v_ff[NS-1];
   assign out_num        = big ? b7_11_ff : {b7_11_ff[30:0], 1'b0};
   assign out_den        = b4_11_ff;
   assign out_side.big   = big;
   assign out_side.temp  = t_ff[NS-1];
   assign out_side.fault = f_ff[NS-1];

endmodule

`default_nettype wire

// ===== rtl/bcc_tail.sv =====
// bcc_tail: quadratic pressure correction and saturation, five stages
// last stage is the output register; depends on bcc_pkg
`default_nettype none

module bcc_tail
   import bcc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  in_valid,
   input  wire logic [PRES_NUM_W-1:0] in_quo,
   input  wire mid_side_type          in_side,
   output logic                       out_valid,
   output logic signed [15:0]         out_temp,
   output logic        [17:0]         out_pres,
   output logic                       out_fault
);

   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic               f1_ff, f2_ff, f3_ff, f4_ff, f5_ff;
   logic signed [15:0] t1_ff, t2_ff, t3_ff, t4_ff, t5_ff;
   logic        [31:0] q1_ff, q2_ff, q3_ff, q4_ff, q_in;
   logic        [23:0] hq;
   logic        [47:0] sqp_2_ff;
   logic signed [48:0] x2p_prod;
   logic signed [32:0] x2p_2_ff, x2p_3_ff;
   logic        [59:0] x1p_prod;
   logic        [43:0] x1p_3_ff;
   logic signed [45:0] corr_sum;
   logic signed [41:0] corr_4_ff;
   logic signed [45:0] psum;
   logic        [17:0] p_in;
   logic        [17:0] p5_ff;

   // stage 1: undo the numerator pre-scaling
   assign q_in = in_side.big ? {in_quo[30:0], 1'b0} : in_quo;

   // stage 2: square term and linear term
   assign hq       = q1_ff[31:8];
   assign x2p_prod = $signed({1'b0, q1_ff}) * PC_X2;

   // stage 3: scale the square term
   assign x1p_prod = {12'b0, sqp_2_ff} * {48'b0, PC_X1};

   // stage 4: correction sum
   assign corr_sum = $signed({2'b00, x1p_3_ff}) + x2p_3_ff + PC_OFFSET;

   // stage 5: corrected pressure with saturation
   always_comb begin
      psum = $signed({14'b0, q4_ff}) + corr_4_ff;
      if (psum < 46'sd0) begin
         p_in = '0;
      end else if (psum > $signed({28'b0, PRES_MAX})) begin
         p_in = PRES_MAX;
      end else begin
         p_in = psum[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q1_ff     <= q_in;
         f1_ff     <= in_side.fault;
         t1_ff     <= in_side.temp;
         sqp_2_ff  <= {24'b0, hq} * {24'b0, hq};
         x2p_2_ff  <= x2p_prod[48:16];
         q2_ff     <= q1_ff;
         f2_ff     <= f1_ff;
         t2_ff     <= t1_ff;
         x1p_3_ff  <= x1p_prod[59:16];
         x2p_3_ff  <= x2p_2_ff;
         q3_ff     <= q2_ff;
         f3_ff     <= f2_ff;
         t3_ff     <= t2_ff;
         corr_4_ff <= corr_sum[45:4];
         q4_ff     <= q3_ff;
         f4_ff     <= f3_ff;
         t4_ff     <= t3_ff;
         p5_ff     <= f4_ff ? 18'd0 : p_in;
         t5_ff     <= f4_ff ? 16'sd0 : t4_ff;
         f5_ff     <= f4_ff;
      end
   end

   assign out_valid = v5_ff;
   assign out_temp  = t5_ff;
   assign out_pres  = p5_ff;
   assign out_fault = f5_ff;

endmodule

`default_nettype wire

// ===== verif/tb_barometer_compensation_core.sv =====
// tb_barometer_compensation_core: self-checking testbench of the barometer compensation core
// drives raw reading words, predicts compensated results, checks them in order
// depends on bcc_pkg and barometer_compensation_core
`timescale 1ns / 1ps

module tb_barometer_compensation_core;
   import bcc_pkg::*;

   typedef struct {
      logic signed [15:0] temperature;
      logic        [17:0] pressure;
      logic               div_fault;
   } comp_result_type;

   typedef struct {
      bit         is_csr;
      logic [1:0] csr_idx;
      logic [63:0] csr_val;
      logic [15:0] raw_t;
      logic [23:0] raw_p;
   } pending_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   barometer_compensation_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   localparam int LATENCY = 79;
   localparam int CYCLE_LIMIT = 400000;

   // predictor copy of the calibration registers
   logic [63:0] pred_cal_a, pred_cal_b;
   logic [47:0] pred_cal_c;
   logic [1:0]  pred_oss;

   pending_type     word_queue[$];
   comp_result_type expected_results[$];
   int              mismatch_count;
   int              cycle_count;
   int              hold_off;
   bit              long_stall_req;
   int              gap_left;
   int              burst_left;
   int              csr_quiet;

   // arithmetic shift right with floor
   function automatic longint floor_shift(longint x, int n);
      return x >>> n;
   endfunction

   // temperature and pressure compensation at the current calibration
   function automatic comp_result_type compensate(logic [15:0] raw_t, logic [23:0] raw_p);
      comp_result_type r;
      longint ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ac4;
      longint ut, up, x1, x2, x3, b3, b5, b6, t, p, sq, den;
      longint unsigned b4, b7, q;
      int oss;
      ac1 = longint'($signed(pred_cal_a[63:48]));
      ac2 = longint'($signed(pred_cal_a[47:32]));
      ac3 = longint'($signed(pred_cal_a[31:16]));
      ac4 = longint'({48'd0, pred_cal_a[15:0]});
      ac5 = longint'({48'd0, pred_cal_b[63:48]});
      ac6 = longint'({48'd0, pred_cal_b[47:32]});
      b1  = longint'($signed(pred_cal_b[31:16]));
      b2  = longint'($signed(pred_cal_b[15:0]));
      mc  = longint'($signed(pred_cal_c[31:16]));
      md  = longint'($signed(pred_cal_c[15:0]));
      oss = pred_oss;
      ut = longint'({48'd0, raw_t});
      up = longint'({40'd0, raw_p}) >> (8 - oss);
      r.temperature = 0;
      r.pressure = 0;
      r.div_fault = 1;
      x1 = floor_shift((ut - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 0) return r;
      x2 = (mc * 2048) / den;
      b5 = x1 + x2;
      t = floor_shift(b5 + 8, 4);
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      b6 = b5 - 4000;
      sq = floor_shift(b6 * b6, 12);
      x1 = floor_shift(b2 * sq, 11);
      x2 = floor_shift(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = ((ac1 * 4 + x3) * (longint'(1) << oss) + 2) / 4;
      x1 = floor_shift(ac3 * b6, 13);
      x2 = floor_shift(b1 * sq, 16);
      x3 = floor_shift(x1 + x2 + 2, 2);
      b4 = ((longint'(ac4) * ((x3 + 32768) & 64'hFFFF_FFFF)) & 64'hFFFF_FFFF) >> 15;
      if (b4 == 0) return r;
      b7 = (((up - b3) & 64'hFFFF_FFFF) * (50000 >> oss)) & 64'hFFFF_FFFF;
      if (b7 < 64'h8000_0000) q = (b7 * 2) / b4;
      else q = ((b7 / b4) * 2) & 64'hFFFF_FFFF;
      p = longint'(q);
      x1 = (p >>> 8) * (p >>> 8);
      x1 = floor_shift(x1 * 3038, 16);
      x2 = floor_shift(-7357 * p, 16);
      p += floor_shift(x1 + x2 + 3791, 4);
      if (p < 0) p = 0;
      if (p > 262143) p = 262143;
      r.temperature = t[15:0];
      r.pressure = p[17:0];
      r.div_fault = 0;
      return r;
   endfunction

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // reset and cycle limit
   initial begin
      reset = 1;
      repeat (8) @(posedge clock);
      reset <= 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("barometer_compensation_core regression: fail");
         $finish;
      end
   end

   // driver: request words and calibration writes from one queue
   always @(posedge clock) begin
      int burst_now;
      if (reset) begin
         req_tvalid <= 0;
         csr_valid <= 0;
         gap_left <= 0;
         burst_left <= 0;
         csr_quiet <= 0;
      end else begin
         burst_now = burst_left;
         if (req_tvalid && req_tready) begin
            expected_results.push_back(compensate(req_tdata[15:0], req_tdata[39:16]));
            burst_now = burst_left - 1;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CAL_A: pred_cal_a = csr_data;
               CSR_CAL_B: pred_cal_b = csr_data;
               CSR_CAL_C: pred_cal_c = csr_data[47:0];
               CSR_OSS:   pred_oss   = csr_data[1:0];
               default: ;
            endcase
         end
         if ((req_tvalid && !req_tready) || (csr_valid && !csr_ready)) begin
            // hold the offered word
         end else if (word_queue.size() == 0) begin
            req_tvalid <= 0;
            csr_valid <= 0;
         end else if (word_queue[0].is_csr) begin
            req_tvalid <= 0;
            // a write waits for a drained pipeline and a quiet spell
            if (expected_results.size() != 0 || (req_tvalid && req_tready)) begin
               csr_valid <= 0;
               csr_quiet <= 0;
            end else if (csr_quiet < LATENCY + 4) begin
               csr_valid <= 0;
               csr_quiet <= csr_quiet + 1;
            end else begin
               csr_valid <= 1;
               csr_index <= word_queue[0].csr_idx;
               csr_data <= word_queue[0].csr_val;
               csr_quiet <= 0;
               void'(word_queue.pop_front());
            end
         end else if (gap_left > 0) begin
            req_tvalid <= 0;
            csr_valid <= 0;
            gap_left <= gap_left - 1;
         end else if (burst_now <= 0) begin
            // burst over: pick the next burst length and gap
            req_tvalid <= 0;
            csr_valid <= 0;
            burst_now = $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         end else begin
            csr_valid <= 0;
            req_tvalid <= 1;
            req_tdata <= {word_queue[0].raw_p, word_queue[0].raw_t};
            void'(word_queue.pop_front());
         end
         burst_left <= burst_now;
      end
   end

   // receiver stall pattern, with one long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         hold_off <= 0;
      end else if (long_stall_req && hold_off == 0) begin
         hold_off <= 400;
         rsp_tready <= 0;
      end else if (hold_off > 1) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else begin
         hold_off <= (hold_off == 1) ? -1 : hold_off;
         case ((cycle_count / 500) % 3)
            0: rsp_tready <= 1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 1) != 0);
         endcase
      end
   end

   // monitor: compare each result word with the oldest expectation
   always @(posedge clock) begin
      comp_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
               $display("unexpected result word %h fault %b", rsp_tdata, rsp_tuser);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[15:0] !== want.temperature || rsp_tdata[33:16] !== want.pressure
                || rsp_tuser[0] !== want.div_fault || rsp_tdata[39:34] !== 6'd0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("mismatch: want t=%0d p=%0d f=%b got t=%0d p=%0d f=%b",
                           want.temperature, want.pressure, want.div_fault,
                           $signed(rsp_tdata[15:0]), rsp_tdata[33:16], rsp_tuser[0]);
            end
         end
      end
   end

   task automatic add_csr(csr_index_type idx, logic [63:0] val);
      pending_type w;
      w = '{default: '0};
      w.is_csr = 1;
      w.csr_idx = idx;
      w.csr_val = val;
      word_queue.push_back(w);
   endtask

   task automatic add_reading(logic [15:0] rt, logic [23:0] rp);
      pending_type w;
      w = '{default: '0};
      w.raw_t = rt;
      w.raw_p = rp;
      word_queue.push_back(w);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // typical datasheet-like calibration with random jitter
   task automatic add_typical_cal(logic [1:0] oss);
      logic [15:0] j;
      j = 16'($urandom_range(0, 63));
      add_csr(CSR_CAL_A, {16'd408 + j, -16'sd72, -16'sd14383, 16'd32741 - j});
      add_csr(CSR_CAL_B, {16'd32757, 16'd23153 + j, 16'd6190, 16'd4});
      add_csr(CSR_CAL_C, {16'h8000, -16'sd8711 + j, 16'd2868});
      add_csr(CSR_OSS, {62'd0, oss});
   endtask

   // stimulus
   initial begin
      int phase;
      mismatch_count = 0;
      cycle_count = 0;
      long_stall_req = 0;
      pred_cal_a = 0;
      pred_cal_b = 0;
      pred_cal_c = 0;
      pred_oss = 0;
      req_tvalid = 0;
      req_tdata = 0;
      csr_valid = 0;
      csr_index = CSR_CAL_A;
      csr_data = 0;
      rsp_tready = 0;

      // directed: reset calibration gives a zero temperature divisor
      add_reading(16'h0000, 24'h000000);
      add_reading(16'hFFFF, 24'hFFFFFF);
      add_typical_cal(2'd0);
      add_reading(16'd27898, 24'd23843 << 8);
      add_reading(16'h0000, 24'h000000);
      add_reading(16'hFFFF, 24'hFFFFFF);
      add_reading(16'h5555, 24'hAAAAAA);
      add_csr(CSR_OSS, 64'd3);
      add_reading(16'd27898, 24'h5D2300);
      add_reading(16'hFFFF, 24'hFFFFFF);
      add_reading(16'h0000, 24'h000001);
      // zero pressure divisor: ac4 zero
      add_csr(CSR_CAL_A, {16'd408, -16'sd72, -16'sd14383, 16'd0});
      add_reading(16'd27898, 24'h5D2300);
      // zero temperature divisor: ac5 zero makes x1 zero, and md is zero
      add_csr(CSR_CAL_B, {16'd0, 16'd100, 16'd6190, 16'd4});
      add_csr(CSR_CAL_C, {16'h0, 16'h7FFF, 16'h0000});
      add_reading(16'd1234, 24'h123456);
      // extreme calibration
      add_csr(CSR_CAL_A, 64'hFFFF_FFFF_FFFF_FFFF);
      add_csr(CSR_CAL_B, 64'hFFFF_FFFF_FFFF_FFFF);
      add_csr(CSR_CAL_C, 64'hFFFF_FFFF_FFFF);
      add_reading(16'hFFFF, 24'hFFFFFF);
      add_reading(16'h0000, 24'h000000);
      add_csr(CSR_CAL_A, 64'h7FFF_7FFF_7FFF_FFFF);
      add_csr(CSR_CAL_B, 64'hFFFF_0000_7FFF_7FFF);
      add_csr(CSR_CAL_C, 64'h7FFF_7FFF_0001);
      add_reading(16'hFFFF, 24'hFFFFFF);
      add_reading(16'h0000, 24'h800000);

      // random phases: mostly plausible calibration, some fully random
      for (phase = 0; phase < 12; phase++) begin
         if (phase % 3 == 2) begin
            add_csr(CSR_CAL_A, rand64());
            add_csr(CSR_CAL_B, rand64());
            add_csr(CSR_CAL_C, rand64());
            add_csr(CSR_OSS, 64'($urandom_range(0, 3)));
         end else begin
            add_typical_cal(2'(phase % 4));
         end
         repeat (110) begin
            if ($urandom_range(0, 3) == 0)
               add_reading(16'($urandom()), 24'($urandom()));
            else
               add_reading(16'($urandom_range(20000, 36000)),
                           24'($urandom_range(20000, 50000) << 8 | $urandom_range(0, 255)));
         end
         // long receiver hold-off while plenty of readings are still offered
         if (phase == 4) begin
            wait (word_queue.size() < 100);
            long_stall_req = 1;
         end
         // wait for the block to drain at this setting before the next phase
         wait (word_queue.size() == 0);
         if (phase == 5) long_stall_req = 0;
         wait (expected_results.size() == 0);
      end

      wait (word_queue.size() == 0);
      @(posedge clock);
      wait (expected_results.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("barometer_compensation_core regression: pass");
      else
         $display("barometer_compensation_core regression: fail");
      $finish;
   end

endmodule
